[design/swmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swmc_pkg;

  localparam int SWMC_MAX_WINDOW = 16;
  localparam int DATA_W          = 32;
  localparam int WIN_W           = 5;
  localparam int FRAC_W          = 16;
  localparam int PROD_W          = 2 * DATA_W - FRAC_W;
  localparam int ACC_W           = 56;
  localparam int DIV_LANES       = 3;
  localparam int DIV_RADIX_BITS  = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 2;
  localparam int PC_W            = 4;

  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_WINDOW = '0;

  typedef enum logic [PC_W-1:0] {
    PC_IDLE,
    PC_SUM_RD,
    PC_SUM_ADD,
    PC_MDIV_LD,
    PC_MDIV,
    PC_MEAN_SET,
    PC_COV_RD,
    PC_COV_DEV,
    PC_COV_MUL,
    PC_COV_ACC,
    PC_CDIV_LD,
    PC_CDIV,
    PC_COV_SET,
    PC_OUT
  } pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SUM,
    OP_MDIV_LD,
    OP_MEAN_SET,
    OP_DEV,
    OP_MUL,
    OP_ACC,
    OP_CDIV_LD,
    OP_COV_SET,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_WAIT_IN,
    J_LOOP,
    J_DIV,
    J_SINGLE,
    J_EMIT
  } jmp_t;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    pc_t  target;
  } uword_t;

  function automatic uword_t swmc_ucode(input pc_t pc);
    uword_t uw;
    case (pc)
      PC_IDLE:     uw = '{op: OP_ACCEPT,   jmp: J_WAIT_IN, target: PC_IDLE};
      PC_SUM_RD:   uw = '{op: OP_NOP,      jmp: J_NEXT,    target: PC_IDLE};
      PC_SUM_ADD:  uw = '{op: OP_SUM,      jmp: J_LOOP,    target: PC_SUM_RD};
      PC_MDIV_LD:  uw = '{op: OP_MDIV_LD,  jmp: J_NEXT,    target: PC_IDLE};
      PC_MDIV:     uw = '{op: OP_NOP,      jmp: J_DIV,     target: PC_IDLE};
      PC_MEAN_SET: uw = '{op: OP_MEAN_SET, jmp: J_SINGLE,  target: PC_OUT};
      PC_COV_RD:   uw = '{op: OP_NOP,      jmp: J_NEXT,    target: PC_IDLE};
      PC_COV_DEV:  uw = '{op: OP_DEV,      jmp: J_NEXT,    target: PC_IDLE};
      PC_COV_MUL:  uw = '{op: OP_MUL,      jmp: J_NEXT,    target: PC_IDLE};
      PC_COV_ACC:  uw = '{op: OP_ACC,      jmp: J_LOOP,    target: PC_COV_RD};
      PC_CDIV_LD:  uw = '{op: OP_CDIV_LD,  jmp: J_NEXT,    target: PC_IDLE};
      PC_CDIV:     uw = '{op: OP_NOP,      jmp: J_DIV,     target: PC_IDLE};
      PC_COV_SET:  uw = '{op: OP_COV_SET,  jmp: J_NEXT,    target: PC_IDLE};
      PC_OUT:      uw = '{op: OP_EMIT,     jmp: J_EMIT,    target: PC_IDLE};
      default:     uw = '{op: OP_NOP,      jmp: J_GOTO,    target: PC_IDLE};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

[design/swmc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface swmc_in_if import swmc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_x;
  logic signed [DATA_W-1:0] sample_y;

  modport source (output valid, sample_x, sample_y, input ready);
  modport sink (input valid, sample_x, sample_y, output ready);
endinterface

interface swmc_out_if import swmc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mean_x;
  logic signed [DATA_W-1:0] mean_y;
  logic        [DATA_W-2:0] cov_xx;
  logic signed [DATA_W-1:0] cov_xy;
  logic        [DATA_W-2:0] cov_yy;
  logic        [WIN_W-1:0]  samples_used;

  modport source (output valid, mean_x, mean_y, cov_xx, cov_xy, cov_yy, samples_used,
                  input ready);
  modport sink (input valid, mean_x, mean_y, cov_xx, cov_xy, cov_yy, samples_used,
                output ready);
endinterface

`default_nettype wire

[design/swmc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module swmc_div import swmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend [DIV_LANES],
  input  logic        [WIN_W-1:0] divisor,
  output logic                    busy,
  output logic signed [ACC_W:0]   quotient [DIV_LANES]
);

  localparam int NSTEP = ACC_W / DIV_RADIX_BITS;
  localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [ACC_W-1:0] quo_r   [DIV_LANES];
  logic [ACC_W-1:0] quo_nxt [DIV_LANES];
  logic [WIN_W-1:0] rem_r   [DIV_LANES];
  logic [WIN_W-1:0] rem_nxt [DIV_LANES];
  logic             neg_r   [DIV_LANES];
  logic [WIN_W-1:0] dvs_r;
  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;

  // restoring division, several quotient bits per cycle, magnitudes only
  always_comb begin
    logic [WIN_W:0]   trial;
    logic [WIN_W-1:0] rem_v;
    logic [ACC_W-1:0] quo_v;
    for (int l = 0; l < DIV_LANES; l++) begin
      rem_v = rem_r[l];
      quo_v = quo_r[l];
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
        trial = {rem_v, quo_v[ACC_W-1]};
        quo_v = {quo_v[ACC_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_r}) begin
          rem_v    = WIN_W'(trial - {1'b0, dvs_r});
          quo_v[0] = 1'b1;
        end else begin
          rem_v = trial[WIN_W-1:0];
        end
      end
      quo_nxt[l] = quo_v;
      rem_nxt[l] = rem_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NSTEP - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      for (int l = 0; l < DIV_LANES; l++) begin
        neg_r[l] <= dividend[l][ACC_W-1];
        rem_r[l] <= '0;
        quo_r[l] <= dividend[l][ACC_W-1] ? ACC_W'(-dividend[l]) : ACC_W'(dividend[l]);
      end
    end else if (busy_r) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        quo_r[l] <= quo_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  assign busy = busy_r;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      quotient[l] = neg_r[l] ? -$signed({1'b0, quo_r[l]}) : $signed({1'b0, quo_r[l]});
    end
  end

endmodule

`default_nettype wire

[design/sliding_window_mean_covariance.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in_ch     in   valid/ready          sample_x, sample_y (signed Q16.16)
// out_ch    out  valid/ready          mean_x, mean_y, cov_xx, cov_xy, cov_yy, samples_used
// APB       in   psel/penable/pwrite  window_length at byte address 0
//
// One transaction at a time; the single read port of the sample store is walked
// once for the means and once more for the covariances, each followed by a 14-step
// pass of the shared divider; with one stored sample the second walk and pass are skipped.
// Synchronous active-low reset empties the window and sets window_length to 16.
// A new transaction is taken while the previous result still waits in the output
// register; a stalled output holds the sequencer at its final step.

module sliding_window_mean_covariance import swmc_pkg::*; #(
  parameter int MAX_WINDOW = SWMC_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swmc_in_if.sink               in_ch,
  swmc_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [WIN_W-1:0] WMAX    = (MAX_WINDOW >= 31) ? 5'd31 : 5'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] RST_WIN = (MAX_WINDOW >= 16) ? 5'd16 : 5'(MAX_WINDOW);
  localparam int QW = ACC_W + 1;
  localparam logic signed [QW-1:0] Q_MAX = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-64'sd2147483648);

  pc_t              pc_r, pc_nxt;
  uword_t           uw;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [WIN_W-1:0] slot_r, slot_nxt;
  logic [WIN_W-1:0] fill_r, fill_nxt;
  logic [WIN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r;

  logic             in_fire;
  logic             out_free;
  logic             more;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_win;

  logic [2*DATA_W-1:0] mem [MAX_WINDOW];
  logic [2*DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] rdx, rdy;

  logic signed [ACC_W-1:0] acc_r [DIV_LANES];
  logic signed [DATA_W-1:0] mx_r, my_r;
  logic [DATA_W-1:0]        dxm_r, dym_r;
  logic                     dxn_r, dyn_r;
  logic [PROD_W-1:0]        pr_r [DIV_LANES];
  logic                     pn_r [DIV_LANES];
  logic [DATA_W-2:0]        cxx_r, cyy_r;
  logic signed [DATA_W-1:0] cxy_r;

  logic signed [DATA_W:0]   dx, dy;
  logic [2*DATA_W-1:0]      pxx, pxy, pyy;
  logic signed [ACC_W-1:0]  term [DIV_LANES];

  logic                     div_start;
  logic                     div_busy;
  logic [WIN_W-1:0]         div_dvs;
  logic signed [QW-1:0]     quo [DIV_LANES];

  logic signed [DATA_W-1:0] omx_r, omy_r, ocxy_r;
  logic [DATA_W-2:0]        ocxx_r, ocyy_r;
  logic [WIN_W-1:0]         on_r;

  // control decode
  always_comb begin
    uw          = swmc_ucode(pc_r);
    in_ch.ready = (uw.op == OP_ACCEPT);
    div_start   = (uw.op == OP_MDIV_LD) || (uw.op == OP_CDIV_LD);
    div_dvs     = (uw.op == OP_MDIV_LD) ? fill_r : fill_r - 5'd1;
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign more     = ({1'b0, idx_r} + 6'd1) < {1'b0, fill_r};

  // next step
  always_comb begin
    case (uw.jmp)
      J_NEXT:    pc_nxt = pc_t'(pc_r + 4'd1);
      J_GOTO:    pc_nxt = uw.target;
      J_WAIT_IN: pc_nxt = in_fire ? pc_t'(pc_r + 4'd1) : pc_r;
      J_LOOP:    pc_nxt = more ? uw.target : pc_t'(pc_r + 4'd1);
      J_DIV:     pc_nxt = div_busy ? pc_r : pc_t'(pc_r + 4'd1);
      J_SINGLE:  pc_nxt = (fill_r == 5'd1) ? uw.target : pc_t'(pc_r + 4'd1);
      J_EMIT:    pc_nxt = out_free ? uw.target : pc_r;
      default:   pc_nxt = PC_IDLE;
    endcase
  end

  // configuration
  assign cfg_we = psel && penable && pwrite && (paddr == CFG_ADDR_WINDOW);
  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_WINDOW) ? {{(CFG_DATA_W-WIN_W){1'b0}}, win_r} : '0;

  always_comb begin
    cfg_win = pwdata[WIN_W-1:0];
    if (cfg_win == '0) begin
      cfg_win = 5'd1;
    end else if (cfg_win > WMAX) begin
      cfg_win = WMAX;
    end
  end

  // window bookkeeping
  always_comb begin
    win_nxt  = win_r;
    slot_nxt = slot_r;
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    if (cfg_we) begin
      win_nxt  = cfg_win;
      slot_nxt = '0;
      fill_nxt = '0;
    end else begin
      case (uw.op)
        OP_ACCEPT: begin
          if (in_fire) begin
            slot_nxt = ((slot_r + 5'd1) == win_r) ? '0 : slot_r + 5'd1;
            fill_nxt = (fill_r < win_r) ? fill_r + 5'd1 : win_r;
            idx_nxt  = '0;
          end
        end
        OP_SUM, OP_ACC: idx_nxt = idx_r + 5'd1;
        OP_MEAN_SET:    idx_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      win_r       <= RST_WIN;
      slot_r      <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      win_r  <= win_nxt;
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      if (uw.op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[IW'(slot_r)] <= {in_ch.sample_x, in_ch.sample_y};
    end
    rd_r <= mem[IW'(idx_r)];
  end

  assign rdx = rd_r[2*DATA_W-1:DATA_W];
  assign rdy = rd_r[DATA_W-1:0];

  assign dx  = {rdx[DATA_W-1], rdx} - {mx_r[DATA_W-1], mx_r};
  assign dy  = {rdy[DATA_W-1], rdy} - {my_r[DATA_W-1], my_r};
  assign pxx = dxm_r * dxm_r;
  assign pxy = dxm_r * dym_r;
  assign pyy = dym_r * dym_r;

  always_comb begin
    for (int k = 0; k < DIV_LANES; k++) begin
      term[k] = pn_r[k] ? -$signed({{(ACC_W-PROD_W){1'b0}}, pr_r[k]})
                        :  $signed({{(ACC_W-PROD_W){1'b0}}, pr_r[k]});
    end
  end

  swmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (quo)
  );

  // datapath
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_ACCEPT: begin
        if (in_fire) begin
          for (int k = 0; k < DIV_LANES; k++) acc_r[k] <= '0;
        end
      end
      OP_SUM: begin
        acc_r[0] <= acc_r[0] + {{(ACC_W-DATA_W){rdx[DATA_W-1]}}, rdx};
        acc_r[1] <= acc_r[1] + {{(ACC_W-DATA_W){rdy[DATA_W-1]}}, rdy};
      end
      OP_MEAN_SET: begin
        mx_r  <= quo[0][DATA_W-1:0];
        my_r  <= quo[1][DATA_W-1:0];
        cxx_r <= '0;
        cxy_r <= '0;
        cyy_r <= '0;
        for (int k = 0; k < DIV_LANES; k++) acc_r[k] <= '0;
      end
      OP_DEV: begin
        dxn_r <= dx[DATA_W];
        dyn_r <= dy[DATA_W];
        dxm_r <= dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
        dym_r <= dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
      end
      OP_MUL: begin
        pr_r[0] <= pxx[2*DATA_W-1:FRAC_W];
        pr_r[1] <= pxy[2*DATA_W-1:FRAC_W];
        pr_r[2] <= pyy[2*DATA_W-1:FRAC_W];
        pn_r[0] <= 1'b0;
        pn_r[1] <= dxn_r ^ dyn_r;
        pn_r[2] <= 1'b0;
      end
      OP_ACC: begin
        for (int k = 0; k < DIV_LANES; k++) acc_r[k] <= acc_r[k] + term[k];
      end
      OP_COV_SET: begin
        cxx_r <= (quo[0] < 0) ? '0 : (quo[0] > Q_MAX) ? '1 : quo[0][DATA_W-2:0];
        cyy_r <= (quo[2] < 0) ? '0 : (quo[2] > Q_MAX) ? '1 : quo[2][DATA_W-2:0];
        cxy_r <= (quo[1] > Q_MAX) ? Q_MAX[DATA_W-1:0] :
                 (quo[1] < Q_MIN) ? Q_MIN[DATA_W-1:0] : quo[1][DATA_W-1:0];
      end
      OP_EMIT: begin
        if (out_free) begin
          omx_r  <= mx_r;
          omy_r  <= my_r;
          ocxx_r <= cxx_r;
          ocxy_r <= cxy_r;
          ocyy_r <= cyy_r;
          on_r   <= fill_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean_x       = omx_r;
  assign out_ch.mean_y       = omy_r;
  assign out_ch.cov_xx       = ocxx_r;
  assign out_ch.cov_xy       = ocxy_r;
  assign out_ch.cov_yy       = ocyy_r;
  assign out_ch.samples_used = on_r;

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count beyond window");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < win_r)
    else $error("write slot outside window");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pc_r == PC_SUM_RD && idx_r == '0 && fill_r != '0)
    else $error("accepted transaction did not start the walk");

  a_cov_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == PC_COV_RD |-> fill_r > 5'd1)
    else $error("covariance pass with fewer than two samples");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy && (pc_r == PC_MDIV || pc_r == PC_CDIV))
    else $error("divider not running after start");

endmodule

`default_nettype wire

[tb/sliding_window_mean_covariance_test.sv]
`timescale 1ns / 1ps

module sliding_window_mean_covariance_test;
  import swmc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 68;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } xy_sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mean_x;
    logic signed [DATA_W-1:0] mean_y;
    logic        [DATA_W-2:0] cov_xx;
    logic signed [DATA_W-1:0] cov_xy;
    logic        [DATA_W-2:0] cov_yy;
    logic        [WIN_W-1:0]  samples_used;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  swmc_in_if  in_ch ();
  swmc_out_if out_ch ();

  sliding_window_mean_covariance i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  xy_sample_t    pending_samples[$];
  window_stats_t expected_stats[$];

  logic signed [DATA_W-1:0] hist_x [SWMC_MAX_WINDOW];
  logic signed [DATA_W-1:0] hist_y [SWMC_MAX_WINDOW];
  int win_length;
  int win_slot;
  int win_fill;

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served;
  int hold_left;
  int idle_cycles;
  logic signed [DATA_W-1:0] cluster_center = '0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic longint trunc_q16_product(input longint a, input longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void apply_window_length(input logic [CFG_DATA_W-1:0] word);
    int w;
    w = word[WIN_W-1:0];
    if (w < 1) w = 1;
    if (w > SWMC_MAX_WINDOW) w = SWMC_MAX_WINDOW;
    win_length = w;
    win_slot = 0;
    win_fill = 0;
  endfunction

  function automatic window_stats_t predict_window_stats(input xy_sample_t s);
    window_stats_t r;
    longint sum_x, sum_y, avg_x, avg_y, dx, dy, sxx, sxy, syy;
    int n;
    sum_x = 0;
    sum_y = 0;
    sxx = 0;
    sxy = 0;
    syy = 0;
    if (win_slot >= win_length) win_slot = 0;
    hist_x[win_slot] = s.x;
    hist_y[win_slot] = s.y;
    win_slot = (win_slot + 1) % win_length;
    if (win_fill < win_length) win_fill++;
    n = win_fill;
    for (int i = 0; i < n; i++) begin
      sum_x += hist_x[i];
      sum_y += hist_y[i];
    end
    avg_x = sum_x / n;
    avg_y = sum_y / n;
    if (n > 1) begin
      for (int i = 0; i < n; i++) begin
        dx = longint'(hist_x[i]) - avg_x;
        dy = longint'(hist_y[i]) - avg_y;
        sxx += trunc_q16_product(dx, dx);
        sxy += trunc_q16_product(dx, dy);
        syy += trunc_q16_product(dy, dy);
      end
      sxx = sxx / (n - 1);
      sxy = sxy / (n - 1);
      syy = syy / (n - 1);
    end
    if (sxx > 64'sd2147483647) sxx = 64'sd2147483647;
    if (sxx < 0) sxx = 0;
    if (sxy > 64'sd2147483647) sxy = 64'sd2147483647;
    if (sxy < -64'sd2147483648) sxy = -64'sd2147483648;
    if (syy > 64'sd2147483647) syy = 64'sd2147483647;
    if (syy < 0) syy = 0;
    r.mean_x = avg_x[DATA_W-1:0];
    r.mean_y = avg_y[DATA_W-1:0];
    r.cov_xx = sxx[DATA_W-2:0];
    r.cov_xy = sxy[DATA_W-1:0];
    r.cov_yy = syy[DATA_W-2:0];
    r.samples_used = n[WIN_W-1:0];
    return r;
  endfunction

  // regime: 0 small, 1 cluster around a large offset, 2 full range, 3 medium
  function automatic logic signed [DATA_W-1:0] pick_component(input int regime);
    logic signed [DATA_W-1:0] v;
    case (regime)
      0: v = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      1: v = cluster_center + $signed($urandom_range(4095)) - 32'sd2048;
      2: begin
        case ($urandom_range(7))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          default: v = $urandom;
        endcase
      end
      default: v = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
    return v;
  endfunction

  task automatic queue_sample(input logic signed [DATA_W-1:0] x,
                              input logic signed [DATA_W-1:0] y);
    xy_sample_t s;
    s.x = x;
    s.y = y;
    pending_samples = {pending_samples, s};
  endtask

  task automatic write_window_length(input logic [WIN_W-1:0] length);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[WIN_W-1:0] = length;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_WINDOW;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_window_length(word);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_ch.valid || expected_stats.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    xy_sample_t taken;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken = pending_samples.pop_front();
        expected_stats = {expected_stats, predict_window_stats(taken)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid    <= 1'b1;
          in_ch.sample_x <= pending_samples[0].x;
          in_ch.sample_y <= pending_samples[0].y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    window_stats_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_served  <= 0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("result transaction with no sample outstanding");
        end else begin
          want = expected_stats.pop_front();
          check_field("mean_x", out_ch.mean_x, want.mean_x);
          check_field("mean_y", out_ch.mean_y, want.mean_y);
          check_field("cov_xx", out_ch.cov_xx, want.cov_xx);
          check_field("cov_xy", out_ch.cov_xy, want.cov_xy);
          check_field("cov_yy", out_ch.cov_yy, want.cov_yy);
          check_field("samples_used", out_ch.samples_used, want.samples_used);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served  <= hold_requests;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid === 1'b1 && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_window [PHASES];
    int regime;
    int mode;
    phase_window = '{1, 0, 2, 16, 31, 17, 3, 8, 12, 16};
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    out_ch.ready   = 1'b0;
    idle_cycles    = 0;
    win_length     = 16;
    win_slot       = 0;
    win_fill       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset window of 16: single sample, extremes, saturation, then wrap past 16
    @(negedge clk);
    queue_sample(32'sd0, 32'sd0);
    queue_sample(32'sh7fff_ffff, 32'sh8000_0000);
    queue_sample(32'sh8000_0000, 32'sh7fff_ffff);
    queue_sample(32'sh7fff_ffff, 32'sh7fff_ffff);
    queue_sample(32'sh8000_0000, 32'sh8000_0000);
    queue_sample(-32'sd1, 32'sd1);
    queue_sample(32'sd1, -32'sd1);
    queue_sample(32'sh0001_0000, 32'shffff_0000);
    for (int i = 0; i < 12; i++)
      queue_sample((i <<< 17) - 5, 7 - (i <<< 16));
    wait_drained();

    regime = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_window_length(phase_window[p][WIN_W-1:0]);
      @(negedge clk);
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 53 : (mode == 3) ? 7 : 0;
      recv_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 7 : 0;
      if (p == 3) hold_requests++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(23) == 0) begin
          regime = $urandom_range(3);
          cluster_center = $urandom;
        end
        queue_sample(pick_component(regime), pick_component(regime));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
